>>> rtl/core/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] char_code;
      logic [6:0] target_col;
      logic [4:0] target_row;
   } tccw_req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_offset;
      logic [15:0] cell_data;
      logic        scrolled;
   } tccw_rsp_type;

   typedef struct packed {
      logic wr;
      logic rd;
   } tccw_mem_ctrl_type;

   localparam logic [1:0] OP_PUT     = 2'd0;
   localparam logic [1:0] OP_CLEAR   = 2'd1;
   localparam logic [1:0] OP_SET_POS = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_LINEFEED  = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;

   localparam logic [15:0] RESET_CELL = 16'h0700;

   localparam logic CSR_FOREGROUND = 1'b0;
   localparam logic CSR_BACKGROUND = 1'b1;

   localparam logic [3:0] FG_RESET = 4'd7;
   localparam logic [2:0] BG_RESET = 3'd0;

   function automatic logic [3:0] colour_perm(input logic [3:0] idx);
      logic [3:0] res;
      case (idx)
         4'd0:    res = 4'd0;
         4'd1:    res = 4'd4;
         4'd2:    res = 4'd2;
         4'd3:    res = 4'd6;
         4'd4:    res = 4'd1;
         4'd5:    res = 4'd5;
         4'd6:    res = 4'd3;
         4'd7:    res = 4'd7;
         4'd8:    res = 4'd8;
         4'd9:    res = 4'd12;
         4'd10:   res = 4'd10;
         4'd11:   res = 4'd14;
         4'd12:   res = 4'd9;
         4'd13:   res = 4'd13;
         4'd14:   res = 4'd11;
         default: res = 4'd15;
      endcase
      return res;
   endfunction

   function automatic logic [7:0] colour_attr(input logic [3:0] fg, input logic [2:0] bg);
      logic [3:0] bg_perm;
      bg_perm = colour_perm({1'b0, bg});
      return {1'b0, bg_perm[2:0], colour_perm(fg)};
   endfunction

endpackage

>>> rtl/core/tccw_screen_ram.sv
`timescale 1ns / 1ps

module tccw_screen_ram import tccw_pkg::*; #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic              clock,
   input  tccw_mem_ctrl_type mem_ctrl,
   input  logic [AW-1:0]     mem_addr,
   input  logic [15:0]       mem_wdata,
   output logic [15:0]       mem_rdata
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.wr) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_ctrl.rd) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

>>> rtl/core/tccw_sequencer.sv
`timescale 1ns / 1ps

module tccw_sequencer import tccw_pkg::*; #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 4,
   parameter int AW        = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tccw_req_type      req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tccw_rsp_type      rsp_payload,
   input  logic [7:0]        attr,
   output tccw_mem_ctrl_type mem_ctrl,
   output logic [AW-1:0]     mem_addr,
   output logic [15:0]       mem_wdata,
   input  logic [15:0]       mem_rdata
);

   localparam int CW          = $clog2(COLUMNS);
   localparam int RW          = $clog2(ROWS);
   localparam int TPW         = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 17;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + TAB_WIDTH - 1) / TAB_WIDTH;
   localparam int PW          = CW + RECIP_W;

   localparam logic [CW-1:0]  LAST_COL   = CW'(COLUMNS - 1);
   localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);
   localparam logic [AW-1:0]  LAST_CELL  = AW'(COLUMNS * ROWS - 1);
   localparam logic [AW-1:0]  LAST_SWEEP = AW'(COLUMNS - 1);
   localparam logic [TPW-1:0] LAST_PHASE = TPW'(TAB_WIDTH - 1);
   localparam logic [TPW-1:0] WRAP_PHASE = TPW'((COLUMNS - 1) % TAB_WIDTH);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_TAB    = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_CLEAR  = 3'd4;
   localparam logic [2:0] ST_PHASE1 = 3'd5;
   localparam logic [2:0] ST_PHASE2 = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0]     state_ff, state_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [RW-1:0]  top_ff, top_in;
   logic [TPW-1:0] phase_ff, phase_in;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic [CW-1:0]  quot_ff, quot_in;
   logic           cell_sel_ff, cell_sel_in;
   logic           scrolled_ff, scrolled_in;
   logic           rsp_valid_ff, rsp_valid_in;
   tccw_rsp_type   rsp_ff, rsp_in;

   logic [CW-1:0]  lcol;
   logic [RW-1:0]  lrow;
   logic           sweep_sel;
   logic [RW:0]    prow_sum;
   logic [RW-1:0]  prow;
   logic [AW-1:0]  cell_addr;
   logic [PW-1:0]  quot_prod;
   logic           out_free;

   // logical row -> physical row through the scroll rotation
   always_comb begin
      prow_sum = {1'b0, lrow} + {1'b0, top_ff};
      if (prow_sum >= (RW+1)'(ROWS)) begin
         prow = RW'(prow_sum - (RW+1)'(ROWS));
      end else begin
         prow = RW'(prow_sum);
      end
      cell_addr = AW'(32'(prow) * COLUMNS + 32'(lcol));
      mem_addr  = sweep_sel ? sweep_ff : cell_addr;
   end

   assign quot_prod = PW'(col_ff) * PW'(RECIP);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      top_in       = top_ff;
      phase_in     = phase_ff;
      sweep_in     = sweep_ff;
      quot_in      = quot_ff;
      cell_sel_in  = cell_sel_ff;
      scrolled_in  = scrolled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_ctrl     = '0;
      mem_wdata    = {attr, 8'h00};
      lrow         = row_ff;
      lcol         = col_ff;
      sweep_sel    = 1'b0;
      req_ready    = 1'b0;

      case (state_ff)
         ST_INIT: begin
            mem_ctrl.wr = 1'b1;
            sweep_sel   = 1'b1;
            mem_wdata   = RESET_CELL;
            sweep_in    = sweep_ff + AW'(1);
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               scrolled_in = 1'b0;
               cell_sel_in = 1'b0;
               state_in    = ST_DONE;
               case (req_payload.operation)
                  OP_PUT: begin
                     case (req_payload.char_code)
                        CH_BACKSPACE: begin
                           if (col_ff != '0) begin
                              col_in   = col_ff - CW'(1);
                              phase_in = (phase_ff == '0) ? LAST_PHASE : phase_ff - TPW'(1);
                           end else if (row_ff != '0) begin
                              col_in   = LAST_COL;
                              row_in   = row_ff - RW'(1);
                              phase_in = WRAP_PHASE;
                           end
                        end
                        CH_RETURN: begin
                           col_in   = '0;
                           phase_in = '0;
                        end
                        CH_LINEFEED: begin
                           col_in   = '0;
                           phase_in = '0;
                           if (row_ff == LAST_ROW) begin
                              top_in      = (top_ff == LAST_ROW) ? '0 : top_ff + RW'(1);
                              scrolled_in = 1'b1;
                              state_in    = ST_SCROLL;
                           end else begin
                              row_in = row_ff + RW'(1);
                           end
                        end
                        CH_TAB: begin
                           state_in = ST_TAB;
                        end
                        default: begin
                           mem_ctrl.wr = 1'b1;
                           mem_wdata   = {attr, req_payload.char_code};
                           if (col_ff == LAST_COL) begin
                              col_in   = '0;
                              phase_in = '0;
                              if (row_ff == LAST_ROW) begin
                                 top_in      = (top_ff == LAST_ROW) ? '0 : top_ff + RW'(1);
                                 scrolled_in = 1'b1;
                                 state_in    = ST_SCROLL;
                              end else begin
                                 row_in = row_ff + RW'(1);
                              end
                           end else begin
                              col_in   = col_ff + CW'(1);
                              phase_in = (phase_ff == LAST_PHASE) ? '0 : phase_ff + TPW'(1);
                           end
                        end
                     endcase
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     top_in   = '0;
                     phase_in = '0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_SET_POS: begin
                     col_in   = (32'(req_payload.target_col) < COLUMNS) ?
                                CW'(req_payload.target_col) : LAST_COL;
                     row_in   = (32'(req_payload.target_row) < ROWS) ?
                                RW'(req_payload.target_row) : LAST_ROW;
                     state_in = ST_PHASE1;
                  end
                  OP_READ: begin
                     if ((32'(req_payload.target_col) < COLUMNS) &&
                         (32'(req_payload.target_row) < ROWS)) begin
                        mem_ctrl.rd = 1'b1;
                        lrow        = RW'(req_payload.target_row);
                        lcol        = CW'(req_payload.target_col);
                        cell_sel_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TAB: begin
            mem_ctrl.wr = 1'b1;
            if (col_ff == LAST_COL) begin
               col_in   = '0;
               phase_in = '0;
               state_in = ST_DONE;
               if (row_ff == LAST_ROW) begin
                  top_in      = (top_ff == LAST_ROW) ? '0 : top_ff + RW'(1);
                  scrolled_in = 1'b1;
                  state_in    = ST_SCROLL;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end else begin
               col_in   = col_ff + CW'(1);
               phase_in = (phase_ff == LAST_PHASE) ? '0 : phase_ff + TPW'(1);
               if (phase_ff == LAST_PHASE) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCROLL: begin
            // blank the row that just rotated in at the bottom
            mem_ctrl.wr = 1'b1;
            lcol        = CW'(sweep_ff);
            sweep_in    = sweep_ff + AW'(1);
            if (sweep_ff == LAST_SWEEP) begin
               sweep_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            mem_ctrl.wr = 1'b1;
            sweep_sel   = 1'b1;
            sweep_in    = sweep_ff + AW'(1);
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_PHASE1: begin
            quot_in  = CW'(quot_prod >> RECIP_SHIFT);
            state_in = ST_PHASE2;
         end
         ST_PHASE2: begin
            phase_in = TPW'(32'(col_ff) - 32'(quot_ff) * TAB_WIDTH);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.cursor_col    = 7'(col_ff);
               rsp_in.cursor_row    = 5'(row_ff);
               rsp_in.cursor_offset = 11'(32'(row_ff) * COLUMNS + 32'(col_ff));
               rsp_in.cell_data     = cell_sel_ff ? mem_rdata : 16'h0000;
               rsp_in.scrolled      = scrolled_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         phase_ff     <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         phase_ff     <= phase_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      cell_sel_ff <= cell_sel_in;
      scrolled_ff <= scrolled_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/text_console_character_writer_core.sv
`timescale 1ns / 1ps
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells plus a cursor.
// req channel (valid/ready) carries one operation per transfer: put character,
// clear screen, set cursor position or read cell. Each transfer yields exactly
// one rsp transfer with the cursor after the operation, its linear offset,
// the cell read (zero otherwise) and a scroll flag.
// Blanking work per item: a tab blanks 1 to TAB_WIDTH cells, any scroll
// blanks the COLUMNS cells of the new bottom row and clear screen blanks all
// COLUMNS*ROWS cells; set cursor position passes through ST_PHASE1 and
// ST_PHASE2 to work out the tab phase of the new column.
// The screen memory has one port and every cell blanked takes one write on it;
// scrolling rotates a row pointer, so only the new bottom row is written.
// Items are taken one at a time; req_ready is high only while idle.
// A held rsp (rsp_ready low) keeps its payload; the next result waits inside
// until the output register is free.
// After reset the block blanks all COLUMNS*ROWS cells (one per cycle) with
// attribute 0x07 before raising req_ready. CSR writes are taken at any time.
// CSR map: 0x0 foreground index (reset 7), 0x4 background index (reset 0).

module text_console_character_writer_core import tccw_pkg::*; #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tccw_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output tccw_rsp_type rsp_payload,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   logic [3:0]        fg_ff, fg_in;
   logic [2:0]        bg_ff, bg_in;
   logic              csr_write;
   logic [7:0]        attr;
   tccw_mem_ctrl_type mem_ctrl;
   logic [AW-1:0]     mem_addr;
   logic [15:0]       mem_wdata;
   logic [15:0]       mem_rdata;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_FOREGROUND: fg_in = pwdata[3:0];
            CSR_BACKGROUND: bg_in = pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_FOREGROUND: prdata = {28'd0, fg_ff};
         CSR_BACKGROUND: prdata = {29'd0, bg_ff};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   assign attr = colour_attr(fg_ff, bg_ff);

   tccw_sequencer #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH),
      .AW        (AW)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .attr        (attr),
      .mem_ctrl    (mem_ctrl),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .mem_rdata   (mem_rdata)
   );

   tccw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_screen_ram (
      .clock     (clock),
      .mem_ctrl  (mem_ctrl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer accepted while an item is in progress");

   a_init_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request accepted before the screen clearing pass");

   a_single_mem_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctrl.wr && mem_ctrl.rd))
      else $error("screen memory read and write in the same cycle");

   a_read_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      mem_ctrl.rd |-> req_valid && req_ready)
      else $error("screen memory read outside a read cell transfer");
`endif

endmodule
